// File: rtl/ted_pkg.sv
// ----------------------------------------------------------------------------
// ted_pkg: shared types and constants of the tetrahedron edge dedup block
// Index and count types, the sequencer states and the exchange / pair
// schedules that the sequencer walks through.
// ----------------------------------------------------------------------------
package ted_pkg;

    localparam int IDX_W  = 6;
    localparam int CNT_W  = 12;
    localparam int STEP_W = 3;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [1:0]        t_slot;
    typedef t_idx [3:0]        t_corners;

    // last step of the five-exchange sort and of the six-pair walk
    localparam t_step SORT_LAST = 3'd4;
    localparam t_step PAIR_LAST = 3'd5;

    localparam t_cnt COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_READ,
        ST_TEST
    } t_state;

    // sorting network: (0,1) (2,3) (0,2) (1,3) (1,2)
    localparam t_slot XCH_A [5] = '{2'd0, 2'd2, 2'd0, 2'd1, 2'd1};
    localparam t_slot XCH_B [5] = '{2'd1, 2'd3, 2'd2, 2'd3, 2'd2};

    // corner pairs in output order
    localparam t_slot PAIR_LO [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam t_slot PAIR_HI [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

// File: rtl/ted_ram.sv
// ----------------------------------------------------------------------------
// ted_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ted_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ted_cmpx.sv
// ----------------------------------------------------------------------------
// ted_cmpx: compare-exchange unit
// Orders two vertex indices; shared by every step of the sorting network.
// ----------------------------------------------------------------------------
module ted_cmpx (
    input  ted_pkg::t_idx i_a,
    input  ted_pkg::t_idx i_b,
    output ted_pkg::t_idx o_min,
    output ted_pkg::t_idx o_max
);

    logic swap;

    assign swap  = (i_a > i_b);
    assign o_min = swap ? i_b : i_a;
    assign o_max = swap ? i_a : i_b;

endmodule

// File: rtl/tetra_edge_dedup_top.sv
// ----------------------------------------------------------------------------
// tetra_edge_dedup_top: unique edge extraction for a tetrahedral mesh
// Sorts the corners of each tetrahedron and reports all of its edges,
// flagging those not seen before in the current mesh.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one tetrahedron per transaction, four 6-bit corners in
//   tdata; tlast marks the last tetrahedron of a mesh. Master stream: six
//   transactions per tetrahedron, pairs (s0,s1) (s0,s2) (s0,s3) (s1,s2)
//   (s1,s3) (s2,s3) of the sorted corners; tuser flags a new edge, tdata
//   carries the running unique-edge count, tlast marks the sixth pair.
//   Sequence: no new tetrahedron is taken before the sixth pair of the last
//   is issued. The idle state takes the transaction, the sort runs the
//   exchanges of the network in turn on one compare-exchange unit, then each
//   pair gets a read state and a test state for the read-modify-write of its
//   bitmap row in the row memory; each pair is registered out of its test state.
//   Reset: the row valid bits and the edge counter clear at once, so the
//   bitmap reads empty from the first cycle; no clearing pass is needed.
//   The same happens right after the sixth pair of a tetrahedron with tlast.
//   Stall: a held result keeps the sequencer waiting before its next pair;
//   nothing is dropped. tready is high only while the block is idle.
// ----------------------------------------------------------------------------
module tetra_edge_dedup_top #(
    parameter int NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: corner_a[5:0], corner_b[11:6], corner_c[17:12], corner_d[23:18]
    input  logic [23:0] i_s_axis_tdata,
    // tlast: final_tetra
    input  logic        i_s_axis_tlast,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: edge_low[5:0], edge_high[11:6], unique_edges[23:12]
    output logic [23:0] o_m_axis_tdata,
    // tuser: is_new
    output logic        o_m_axis_tuser,
    // tlast: pair_last
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready
);

    // only indices below 64 ever arrive, so the map needs at most 64 rows
    localparam int ROWS   = (NODES < 64) ? NODES : 64;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int NODE_W = $clog2(NODES + 1) + 1;

    ted_pkg::t_state   r_state, n_state;
    ted_pkg::t_step    r_step, n_step;
    ted_pkg::t_corners r_s, n_s;
    logic              r_final, n_final;
    logic [ROWS-1:0]   r_row_vld, n_row_vld;
    ted_pkg::t_cnt     r_cnt, n_cnt;

    logic              r_out_vld, n_out_vld;
    ted_pkg::t_idx     r_out_low, n_out_low;
    ted_pkg::t_idx     r_out_high, n_out_high;
    logic              r_out_new, n_out_new;
    ted_pkg::t_cnt     r_out_cnt, n_out_cnt;
    logic              r_out_last, n_out_last;

    ted_pkg::t_idx     xa, xb, xmin, xmax;
    ted_pkg::t_idx     lo, hi;
    logic [ROW_AW-1:0] lo_row, hi_col;
    logic              in_range;
    logic [ROWS-1:0]   ram_q, row_cur;
    logic              ram_we, ram_re;
    logic              fresh;
    logic              out_free;

    // shared compare-exchange for the sorting network
    assign xa = r_s[ted_pkg::XCH_A[r_step]];
    assign xb = r_s[ted_pkg::XCH_B[r_step]];

    ted_cmpx u_cmpx (
        .i_a   (xa),
        .i_b   (xb),
        .o_min (xmin),
        .o_max (xmax)
    );

    // current corner pair and its place in the map
    assign lo       = r_s[ted_pkg::PAIR_LO[r_step]];
    assign hi       = r_s[ted_pkg::PAIR_HI[r_step]];
    assign lo_row   = lo[ROW_AW-1:0];
    assign hi_col   = hi[ROW_AW-1:0];
    assign in_range = (NODE_W'(lo) < NODE_W'(NODES)) && (NODE_W'(hi) < NODE_W'(NODES));

    // a row that was never written since the last clear reads as empty
    always_comb begin
        row_cur = '0;
        fresh   = 1'b0;
        if (in_range) begin
            row_cur = r_row_vld[lo_row] ? ram_q : '0;
            fresh   = ~row_cur[hi_col];
        end
    end

    assign out_free = ~r_out_vld | i_m_axis_tready;
    assign ram_re   = (r_state == ted_pkg::ST_READ);
    assign ram_we   = (r_state == ted_pkg::ST_TEST) && out_free && fresh;

    ted_ram #(
        .WIDTH (ROWS),
        .DEPTH (ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (lo_row),
        .i_wdata (row_cur | (ROWS'(1) << hi_col)),
        .i_re    (ram_re),
        .i_raddr (lo_row),
        .o_rdata (ram_q)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ted_pkg::ST_IDLE;
            r_step    <= '0;
            r_row_vld <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_row_vld <= n_row_vld;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s        <= n_s;
        r_final    <= n_final;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_new  <= n_out_new;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    // sequencer: accept, sort, then read and update one row per pair
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_s        = r_s;
        n_final    = r_final;
        n_row_vld  = r_row_vld;
        n_cnt      = r_cnt;
        n_out_vld  = r_out_vld & ~i_m_axis_tready;
        n_out_low  = r_out_low;
        n_out_high = r_out_high;
        n_out_new  = r_out_new;
        n_out_cnt  = r_out_cnt;
        n_out_last = r_out_last;

        case (r_state)
            ted_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_s[0]  = i_s_axis_tdata[5:0];
                    n_s[1]  = i_s_axis_tdata[11:6];
                    n_s[2]  = i_s_axis_tdata[17:12];
                    n_s[3]  = i_s_axis_tdata[23:18];
                    n_final = i_s_axis_tlast;
                    n_step  = '0;
                    n_state = ted_pkg::ST_SORT;
                end
            end
            ted_pkg::ST_SORT: begin
                for (int j = 0; j < 4; j++) begin
                    if (2'(j) == ted_pkg::XCH_A[r_step]) begin
                        n_s[j] = xmin;
                    end else if (2'(j) == ted_pkg::XCH_B[r_step]) begin
                        n_s[j] = xmax;
                    end
                end
                if (r_step == ted_pkg::SORT_LAST) begin
                    n_step  = '0;
                    n_state = ted_pkg::ST_READ;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ted_pkg::ST_READ: begin
                n_state = ted_pkg::ST_TEST;
            end
            ted_pkg::ST_TEST: begin
                if (out_free) begin
                    if (fresh) begin
                        n_row_vld[lo_row] = 1'b1;
                        if (r_cnt != ted_pkg::COUNT_MAX) begin
                            n_cnt = r_cnt + 12'd1;
                        end
                    end
                    n_out_vld  = 1'b1;
                    n_out_low  = lo;
                    n_out_high = hi;
                    n_out_new  = fresh;
                    n_out_cnt  = n_cnt;
                    n_out_last = (r_step == ted_pkg::PAIR_LAST);
                    if (r_step == ted_pkg::PAIR_LAST) begin
                        n_state = ted_pkg::ST_IDLE;
                        // end of mesh: empty the map for the next one
                        if (r_final) begin
                            n_row_vld = '0;
                            n_cnt     = '0;
                        end
                    end else begin
                        n_step  = r_step + 3'd1;
                        n_state = ted_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = ted_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ted_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_cnt, r_out_high, r_out_low};
    assign o_m_axis_tuser  = r_out_new;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: rtl/ted_checker.sv
// ----------------------------------------------------------------------------
// ted_checker: port-level checks of the tetrahedron edge dedup block
// Watches both streams and is bound to the top level below.
// ----------------------------------------------------------------------------
module ted_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic [23:0] i_m_tdata,
    input logic        i_m_tuser,
    input logic        i_m_tlast,
    input logic        i_m_tvalid,
    input logic        i_m_tready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled result changed");

    // the block is busy right after it takes a tetrahedron
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after a transaction");

    // the sorted pair is ordered
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[5:0] <= i_m_tdata[11:6])
        else $error("edge_low above edge_high");

    // a new edge means at least one unique edge counted
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tdata[23:12] != 12'd0)
        else $error("new edge with zero count");

endmodule

bind tetra_edge_dedup_top ted_checker u_ted_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready)
);

// File: tb/tb_tetra_edge_dedup_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tetra_edge_dedup_top: self-checking bench for the tetrahedron edge dedup
// Feeds tetrahedra grouped into meshes. A directed table comes first, then
// random meshes with shared and repeated corners. Each edge transaction
// of a tetrahedron is checked against a local bitmap predictor.
// Both stream sides idle at random, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_tetra_edge_dedup_top;

    localparam int MESH_NODES   = 64;
    localparam int CLK_HALF     = 4;
    localparam int RAND_ITEMS   = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_ROWS_N   = 17;

    // one edge transaction, as the block reports it
    typedef struct packed {
        ted_pkg::t_idx lo;
        ted_pkg::t_idx hi;
        logic          fresh;
        ted_pkg::t_cnt count;
        logic          pair_last;
    } t_edge_exp;

    // directed row: corners, final flag, and optional typed-in results
    // (new-edge mask over the six pairs, count on the sixth pair)
    typedef struct packed {
        ted_pkg::t_idx a;
        ted_pkg::t_idx b;
        ted_pkg::t_idx c;
        ted_pkg::t_idx d;
        logic          fin;
        logic          typed;
        logic [5:0]    new_mask;
        ted_pkg::t_cnt last_count;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{6'd3,  6'd2,  6'd1,  6'd0,  1'b0, 1'b1, 6'b111111, 12'd6},
        '{6'd0,  6'd1,  6'd2,  6'd3,  1'b0, 1'b1, 6'b000000, 12'd6},
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b0, 1'b1, 6'b000001, 12'd7},
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 1'b1, 6'b000001, 12'd8},
        '{6'd63, 6'd0,  6'd63, 6'd0,  1'b0, 1'b1, 6'b000010, 12'd9},
        '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1, 1'b1, 6'b100011, 12'd12},
        '{6'd0,  6'd1,  6'd2,  6'd3,  1'b0, 1'b1, 6'b111111, 12'd6},
        '{6'd5,  6'd4,  6'd3,  6'd2,  1'b1, 1'b1, 6'b111110, 12'd11},
        '{6'd1,  6'd0,  6'd0,  6'd1,  1'b1, 1'b1, 6'b100011, 12'd3},
        '{6'd42, 6'd21, 6'd63, 6'd0,  1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd21, 6'd42, 6'd0,  6'd63, 1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd10, 6'd20, 6'd30, 6'd40, 1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd40, 6'd30, 6'd20, 6'd10, 1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd20, 6'd40, 6'd10, 6'd30, 1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd30, 6'd10, 6'd40, 6'd20, 1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd1,  6'd62, 6'd2,  6'd61, 1'b0, 1'b0, 6'b000000, 12'd0},
        '{6'd62, 6'd1,  6'd61, 6'd2,  1'b1, 1'b0, 6'b000000, 12'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic [23:0] i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;

    // predictor state: one bitmap row per low index, plus the unique count
    logic [MESH_NODES-1:0] seen_rows [MESH_NODES];
    ted_pkg::t_cnt         unique_cnt;
    t_edge_exp             pending_edges [$];

    logic steady_phase;
    logic hold_req;
    int   mismatch_cnt;
    int   tetra_cnt;
    int   mesh_cnt;
    int   edge_cnt;
    int   new_edge_cnt;
    int   peak_count;
    int   cycle_cnt;

    tetra_edge_dedup_top #(
        .NODES(MESH_NODES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d edges outstanding",
                         cycle_cnt, pending_edges.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Sort the corners, walk the six pairs, test-and-mark each in the bitmap.
    // A final tetrahedron reports pre-clear counts, then empties the mesh.
    function automatic void predict_edges(input ted_pkg::t_corners corners,
                                          input logic fin,
                                          output t_edge_exp recs [6]);
        ted_pkg::t_idx s [4];
        ted_pkg::t_idx tmp;
        int            plo [6] = '{0, 0, 0, 1, 1, 2};
        int            phi [6] = '{1, 2, 3, 2, 3, 3};
        for (int i = 0; i < 4; i++) s[i] = corners[i];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (s[j] > s[j+1]) begin
                    tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
                end
        for (int k = 0; k < 6; k++) begin
            recs[k].lo        = s[plo[k]];
            recs[k].hi        = s[phi[k]];
            recs[k].fresh     = 1'b0;
            recs[k].pair_last = (k == 5);
            // out-of-range indices pass through without touching the map
            if (int'(recs[k].lo) < MESH_NODES && int'(recs[k].hi) < MESH_NODES &&
                !seen_rows[recs[k].lo][recs[k].hi]) begin
                seen_rows[recs[k].lo][recs[k].hi] = 1'b1;
                recs[k].fresh = 1'b1;
                if (unique_cnt != ted_pkg::COUNT_MAX) unique_cnt++;
            end
            recs[k].count = unique_cnt;
        end
        if (fin) begin
            foreach (seen_rows[r]) seen_rows[r] = '0;
            unique_cnt = '0;
        end
    endfunction

    // Offer one tetrahedron after a random gap (none in a steady phase); predict on acceptance.
    // Typed-in rows override the new flags and the closing count.
    task automatic send_tetra(input ted_pkg::t_corners corners, input logic fin,
                              input logic typed, input logic [5:0] new_mask,
                              input ted_pkg::t_cnt last_count);
        int        gap;
        t_edge_exp recs [6];
        gap = steady_phase ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= corners;
        i_s_axis_tlast  <= fin;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_edges(corners, fin, recs);
        if (typed) begin
            for (int k = 0; k < 6; k++) recs[k].fresh = new_mask[k];
            recs[5].count = last_count;
        end
        foreach (recs[k]) pending_edges.push_back(recs[k]);
        tetra_cnt++;
        if (fin) mesh_cnt++;
    endtask

    // Corner drawn from a window of the index range; small windows give
    // shared edges and repeated corners, an occasional draw is unrestricted.
    function automatic ted_pkg::t_idx pick_corner(input int base, input int span);
        if ($urandom_range(0, 9) == 0) return ted_pkg::t_idx'($urandom_range(0, 63));
        return ted_pkg::t_idx'(base + $urandom_range(0, span));
    endfunction

    // stimulus
    initial begin
        int                 mesh_len;
        int                 span;
        int                 base;
        int                 rand_sent;
        ted_pkg::t_corners  corners;

        i_rst_n         <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        steady_phase = 1'b0;
        hold_req     = 1'b0;
        mismatch_cnt = 0;
        tetra_cnt    = 0;
        mesh_cnt     = 0;
        foreach (seen_rows[r]) seen_rows[r] = '0;
        unique_cnt = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIR_ROWS[n]) begin
            corners = {DIR_ROWS[n].d, DIR_ROWS[n].c, DIR_ROWS[n].b, DIR_ROWS[n].a};
            send_tetra(corners, DIR_ROWS[n].fin, DIR_ROWS[n].typed,
                       DIR_ROWS[n].new_mask, DIR_ROWS[n].last_count);
        end

        // random meshes; the long receiver hold-off lands on the first one
        hold_req  = 1'b1;
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            mesh_len     = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                       : $urandom_range(1, 20);
            if (mesh_len > RAND_ITEMS - rand_sent) mesh_len = RAND_ITEMS - rand_sent;
            span         = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(2, 20);
            base         = $urandom_range(0, 63 - span);
            steady_phase = ($urandom_range(0, 3) == 0);
            for (int t = 0; t < mesh_len; t++) begin
                for (int i = 0; i < 4; i++) corners[i] = pick_corner(base, span);
                send_tetra(corners, t == mesh_len - 1, 1'b0, '0, '0);
                rand_sent++;
            end
        end
        @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        steady_phase = 1'b0;

        // drain, then allow for anything stray
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d tetrahedra over %0d meshes, %0d edge transactions checked",
                 tetra_cnt, mesh_cnt, edge_cnt);
        $display("%0d new edges reported, highest unique count %0d",
                 new_edge_cnt, peak_count);
        if (mismatch_cnt == 0 && pending_edges.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver: random stall per transaction, one long hold-off on request
    initial begin
        int gap;
        i_m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = steady_phase ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // result checker
    initial begin
        t_edge_exp got;
        t_edge_exp want;
        edge_cnt     = 0;
        new_edge_cnt = 0;
        peak_count   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.lo        = o_m_axis_tdata[5:0];
                got.hi        = o_m_axis_tdata[11:6];
                got.count     = o_m_axis_tdata[23:12];
                got.fresh     = o_m_axis_tuser;
                got.pair_last = o_m_axis_tlast;
                edge_cnt++;
                if (got.fresh) new_edge_cnt++;
                if (int'(got.count) > peak_count) peak_count = int'(got.count);
                if (pending_edges.size() == 0) begin
                    $error("unexpected edge transaction (%0d,%0d)", got.lo, got.hi);
                    mismatch_cnt++;
                end else begin
                    want = pending_edges.pop_front();
                    if (got.lo != want.lo) begin
                        $error("edge_low: expected %0d, got %0d", want.lo, got.lo);
                        mismatch_cnt++;
                    end
                    if (got.hi != want.hi) begin
                        $error("edge_high: expected %0d, got %0d", want.hi, got.hi);
                        mismatch_cnt++;
                    end
                    if (got.fresh != want.fresh) begin
                        $error("is_new: expected %0d, got %0d", want.fresh, got.fresh);
                        mismatch_cnt++;
                    end
                    if (got.count != want.count) begin
                        $error("unique_edges: expected %0d, got %0d",
                               want.count, got.count);
                        mismatch_cnt++;
                    end
                    if (got.pair_last != want.pair_last) begin
                        $error("pair_last: expected %0d, got %0d",
                               want.pair_last, got.pair_last);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

endmodule
